### design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared sizes, word formats, codes and helper functions.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY     = 16;
    localparam int TAG_BITS     = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int RUN_W        = $clog2(RESULT_LIMIT + 1);

    localparam logic [2:0] CLASS_VVIP   = 3'd1;
    localparam logic [2:0] CLASS_VIP    = 3'd2;
    localparam logic [2:0] CLASS_MEMBER = 3'd3;
    localparam logic [2:0] CLASS_GUEST  = 3'd4;
    localparam logic [2:0] CLASS_NONE   = 3'd0;

    localparam logic [1:0] REQ_ADD       = 2'd0;
    localparam logic [1:0] REQ_SERVE_ONE = 2'd1;
    localparam logic [1:0] REQ_SERVE_ALL = 2'd2;
    localparam logic [1:0] REQ_DISMISS   = 2'd3;

    localparam logic [1:0] TABLE_VVIP    = 2'd0;
    localparam logic [1:0] TABLE_VIP     = 2'd1;
    localparam logic [1:0] TABLE_REGULAR = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  priority_class;
        logic [15:0] guest_tag;
    } in_word_t;

    typedef struct packed {
        logic        served_valid;
        logic [15:0] served_tag;
        logic [2:0]  served_class;
        logic [1:0]  table_kind;
        logic [1:0]  result_status;
        logic        last_of_run;
    } out_word_t;

    // One queue entry as held in a cell.
    typedef struct packed {
        logic [2:0]          cls;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctrl_t;

    // Out-of-range classes saturate to the nearest legal class.
    function automatic logic [2:0] sat_class(input logic [2:0] cls);
        logic [2:0] res;
        res = cls;
        if (cls < CLASS_VVIP) begin
            res = CLASS_VVIP;
        end else if (cls > CLASS_GUEST) begin
            res = CLASS_GUEST;
        end
        return res;
    endfunction

    function automatic logic [1:0] table_of(input logic [2:0] cls);
        logic [1:0] res;
        case (cls)
            CLASS_VVIP: res = TABLE_VVIP;
            CLASS_VIP:  res = TABLE_VIP;
            default:    res = TABLE_REGULAR;
        endcase
        return res;
    endfunction

endpackage

### design/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain; holds, inserts or shifts toward the front.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_stays,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               stays
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // An occupied entry of equal or more urgent class keeps its place on an add.
    assign stays = ctrl.occupied && (entry_reg.cls <= new_entry.cls);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            spq_pkg::CELL_INSERT: begin
                if (!stays) begin
                    entry_next = left_stays ? new_entry : left_entry;
                end
            end
            spq_pkg::CELL_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### design/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue top level
// Four-class queue, first-come-first-served within a class, built from a chain of cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a row of cells kept in service
// order. Every cell compares its own class with the class of a new entry at
// once, so an add, a serve-one or a dismiss word gives one result word; a
// new word can be taken in every cycle as long as the result register is
// free or being read and no serve-all run is draining. A serve-all word
// gives one result word per served entry, at most RESULT_LIMIT of them. It
// holds the input side off until its last result word is registered: the
// chain shifts one entry toward the front per cycle and the single result
// register carries one entry per cycle, both only while the result register
// is free or being read. A serve on an empty queue reports the empty status,
// and an add to a full queue leaves the queue as it was and reports the full
// status.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output spq_pkg::out_word_t m_data
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [spq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [spq_pkg::RUN_W-1:0] remain_reg, remain_next;
    logic                      m_valid_reg, m_valid_next;
    spq_pkg::out_word_t        m_data_reg, m_data_next;

    logic                      out_free;
    logic                      accept;
    logic                      do_insert;
    logic                      do_pop;
    logic [spq_pkg::RUN_W-1:0] run_len;
    spq_pkg::entry_t           new_entry;
    spq_pkg::entry_t           front;
    spq_pkg::out_word_t        served_word;

    spq_pkg::entry_t           cell_entry [spq_pkg::CAPACITY];
    logic                      cell_stays [spq_pkg::CAPACITY];
    spq_pkg::cell_ctrl_t       cell_ctrl  [spq_pkg::CAPACITY];

    // The result register is free when empty or when its word leaves now.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign new_entry.cls = spq_pkg::sat_class(s_data.priority_class);
    assign new_entry.tag = spq_pkg::TAG_BITS'(s_data.guest_tag);
    assign front         = cell_entry[0];

    // Number of entries a serve-all word drains.
    assign run_len = (32'(count_reg) > spq_pkg::RESULT_LIMIT)
                   ? spq_pkg::RUN_W'(spq_pkg::RESULT_LIMIT)
                   : spq_pkg::RUN_W'(count_reg);

    always_comb begin
        served_word               = '0;
        served_word.served_valid  = 1'b1;
        served_word.served_tag    = 16'(front.tag);
        served_word.served_class  = front.cls;
        served_word.table_kind    = spq_pkg::table_of(front.cls);
        served_word.result_status = spq_pkg::STATUS_OK;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        do_insert    = 1'b0;
        do_pop       = 1'b0;

        if (accept) begin
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.last_of_run  = 1'b1;
            case (s_data.req_type)
                spq_pkg::REQ_ADD: begin
                    if (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
                        m_data_next.result_status = spq_pkg::STATUS_FULL;
                    end else begin
                        do_insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                spq_pkg::REQ_SERVE_ONE: begin
                    if (count_reg == '0) begin
                        m_data_next.result_status = spq_pkg::STATUS_EMPTY;
                    end else begin
                        do_pop      = 1'b1;
                        count_next  = count_reg - 1'b1;
                        m_data_next = served_word;
                        m_data_next.last_of_run = 1'b1;
                    end
                end
                spq_pkg::REQ_SERVE_ALL: begin
                    if (count_reg == '0) begin
                        m_data_next.result_status = spq_pkg::STATUS_EMPTY;
                    end else begin
                        do_pop      = 1'b1;
                        count_next  = count_reg - 1'b1;
                        remain_next = run_len - 1'b1;
                        m_data_next = served_word;
                        m_data_next.last_of_run = (run_len == spq_pkg::RUN_W'(1));
                        if (run_len != spq_pkg::RUN_W'(1)) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
                spq_pkg::REQ_DISMISS: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end else if (state_reg == ST_DRAIN && out_free) begin
            // One more entry of a serve-all run leaves the front cell.
            do_pop       = 1'b1;
            count_next   = count_reg - 1'b1;
            remain_next  = remain_reg - 1'b1;
            m_valid_next = 1'b1;
            m_data_next  = served_word;
            m_data_next.last_of_run = (remain_reg == spq_pkg::RUN_W'(1));
            if (remain_reg == spq_pkg::RUN_W'(1)) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // The cell chain. Cell 0 is the front of the queue.
    for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
        spq_pkg::entry_t left_e;
        spq_pkg::entry_t right_e;
        logic            left_s;

        always_comb begin
            cell_ctrl[i].occupied = (count_reg > spq_pkg::CNT_W'(i));
            if (do_insert) begin
                cell_ctrl[i].op = spq_pkg::CELL_INSERT;
            end else if (do_pop) begin
                cell_ctrl[i].op = spq_pkg::CELL_POP;
            end else begin
                cell_ctrl[i].op = spq_pkg::CELL_HOLD;
            end
        end

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_s = 1'b1;
        end else begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_s = cell_stays[i-1];
        end

        if (i == spq_pkg::CAPACITY - 1) begin : g_tail
            assign right_e = cell_entry[i];
        end else begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_stays  (left_s),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .stays       (cell_stays[i])
        );
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_drain_remain : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (remain_reg != '0) && (count_reg != '0))
        else $error("drain run with nothing left to serve");

    a_full_add_keeps : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.req_type == spq_pkg::REQ_ADD
         && count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        |=> $stable(count_reg) && m_data_reg.result_status == spq_pkg::STATUS_FULL)
        else $error("add to a full queue changed the queue");

    a_served_class : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.served_valid)
        |-> (m_data_reg.served_class != spq_pkg::CLASS_NONE))
        else $error("served word without a class");

    a_drain_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !accept && out_free)
        |=> m_valid_reg && (m_data_reg.last_of_run == (state_reg == ST_IDLE)))
        else $error("last-of-run flag out of step with the drain run");

endmodule

### tb/stable_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives request words into the four-class queue and checks every result
// word against a predictor that keeps its own copy of the waiting line.
// ----------------------------------------------------------------------------
// The run opens with a short table of directed requests. It covers serves and
// dismisses on an empty queue, class saturation at both ends, every class, a
// fill to capacity with a rejected add, and a full drain. Random requests
// follow in stretches that lean toward adds or toward serves, so the queue
// swings between empty and full. Both handshakes idle at random. Once the
// receiver holds off for a long stretch so the block backs up and stalls its
// input. Once the sender pauses until every predicted word has come back.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;

    localparam int RANDOM_ITEMS  = 105;
    localparam int LONG_HOLD     = 150;
    localparam int TAIL_CYCLES   = 24;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int HOLD_AT_ITEM  = 40;
    localparam int PAUSE_AT_ITEM = 90;

    // One waiting party as the predictor keeps it.
    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] tag;
    } party_t;

    // One row of the directed table. Rows with has_want set carry the status
    // of their single result word, typed in by hand.
    typedef struct packed {
        spq_pkg::in_word_t word;
        logic              has_want;
        logic [1:0]        want_status;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    spq_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    spq_pkg::out_word_t m_data;

    party_t             waiting_line[$];
    spq_pkg::out_word_t due_results[$];
    stim_row_t          stim_rows[$];

    int                 mismatch_count;
    int                 quiet_cycles;
    logic               long_hold_req;

    stable_priority_queue_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A result word that carries no entry, only a status.
    function automatic spq_pkg::out_word_t status_word(input logic [1:0] status);
        spq_pkg::out_word_t w;
        w = '0;
        w.result_status = status;
        w.last_of_run   = 1'b1;
        return w;
    endfunction

    // Takes the front party off the line and queues the word it produces.
    function automatic void serve_front(input logic last);
        party_t             p;
        spq_pkg::out_word_t w;
        p = waiting_line.pop_front();
        w = '0;
        w.served_valid  = 1'b1;
        w.served_tag    = p.tag;
        w.served_class  = p.cls;
        w.result_status = spq_pkg::STATUS_OK;
        w.last_of_run   = last;
        case (p.cls)
            spq_pkg::CLASS_VVIP: w.table_kind = spq_pkg::TABLE_VVIP;
            spq_pkg::CLASS_VIP:  w.table_kind = spq_pkg::TABLE_VIP;
            default:             w.table_kind = spq_pkg::TABLE_REGULAR;
        endcase
        due_results.push_back(w);
    endfunction

    // Applies one accepted request word to the waiting line and queues the
    // result words it must produce, in order.
    function automatic void predict_request(input spq_pkg::in_word_t w);
        logic [2:0] cls;
        party_t     p;
        int         pos;
        int         n;
        int         k;
        case (w.req_type)
            spq_pkg::REQ_ADD: begin
                // Out-of-range classes clamp to the nearest legal one.
                cls = w.priority_class;
                if (cls < spq_pkg::CLASS_VVIP) begin
                    cls = spq_pkg::CLASS_VVIP;
                end else if (cls > spq_pkg::CLASS_GUEST) begin
                    cls = spq_pkg::CLASS_GUEST;
                end
                if (waiting_line.size() >= spq_pkg::CAPACITY) begin
                    due_results.push_back(status_word(spq_pkg::STATUS_FULL));
                end else begin
                    // The newcomer goes behind every equal or more urgent party.
                    pos = 0;
                    while (pos < waiting_line.size() && waiting_line[pos].cls <= cls) begin
                        pos++;
                    end
                    p.cls = cls;
                    p.tag = w.guest_tag;
                    waiting_line.insert(pos, p);
                    due_results.push_back(status_word(spq_pkg::STATUS_OK));
                end
            end
            spq_pkg::REQ_SERVE_ONE: begin
                if (waiting_line.size() == 0) begin
                    due_results.push_back(status_word(spq_pkg::STATUS_EMPTY));
                end else begin
                    serve_front(1'b1);
                end
            end
            spq_pkg::REQ_SERVE_ALL: begin
                if (waiting_line.size() == 0) begin
                    due_results.push_back(status_word(spq_pkg::STATUS_EMPTY));
                end else begin
                    n = waiting_line.size();
                    if (n > spq_pkg::RESULT_LIMIT) begin
                        n = spq_pkg::RESULT_LIMIT;
                    end
                    for (k = 0; k < n; k++) begin
                        serve_front(k == n - 1);
                    end
                end
            end
            spq_pkg::REQ_DISMISS: begin
                waiting_line.delete();
                due_results.push_back(status_word(spq_pkg::STATUS_OK));
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap(input int idle_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_row(input logic [1:0] req, input logic [2:0] cls,
                                    input logic [15:0] tag, input logic has_want,
                                    input logic [1:0] want_status);
        stim_row_t row;
        row.word.req_type       = req;
        row.word.priority_class = cls;
        row.word.guest_tag      = tag;
        row.has_want            = has_want;
        row.want_status         = want_status;
        stim_rows.push_back(row);
    endfunction

    // Offers one request word after an optional gap and returns at the falling
    // edge after it is taken. The word is predicted at the accepting edge. A
    // hand-typed status, when given, replaces the predicted word.
    task automatic offer_word(input spq_pkg::in_word_t w, input int gap,
                              input logic has_want, input logic [1:0] want_status);
        int base;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        base = due_results.size();
        predict_request(w);
        if (has_want) begin
            due_results[base] = status_word(want_status);
        end
        @(negedge aclk);
    endtask

    // Lowers valid and waits until every predicted word has been read.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (due_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------

    task automatic check_result(input spq_pkg::out_word_t got);
        spq_pkg::out_word_t want;
        if (due_results.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            mismatch_count++;
        end else begin
            want = due_results.pop_front();
            if (got.served_valid !== want.served_valid) begin
                $error("served_valid: expected %0d, got %0d",
                       want.served_valid, got.served_valid);
                mismatch_count++;
            end
            if (got.served_tag !== want.served_tag) begin
                $error("served_tag: expected %h, got %h", want.served_tag, got.served_tag);
                mismatch_count++;
            end
            if (got.served_class !== want.served_class) begin
                $error("served_class: expected %0d, got %0d",
                       want.served_class, got.served_class);
                mismatch_count++;
            end
            if (got.table_kind !== want.table_kind) begin
                $error("table_kind: expected %0d, got %0d", want.table_kind, got.table_kind);
                mismatch_count++;
            end
            if (got.result_status !== want.result_status) begin
                $error("result_status: expected %0d, got %0d",
                       want.result_status, got.result_status);
                mismatch_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
                mismatch_count++;
            end
        end
    endtask

    // Outputs are sampled at the rising edge. The watchdog counts cycles in
    // which neither side moves a word and ends the run if the block hangs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: m_ready changes at the falling edge. Stretches alternate
    // between no idling and light or heavy idling. One long hold is taken
    // when the sender asks for it, so the block fills up behind it.
    // ------------------------------------------------------------------------
    initial begin
        int idle_left;
        int stretch_left;
        int idle_pct;
        bit hold_done;
        m_ready      = 1'b0;
        idle_left    = 0;
        stretch_left = 0;
        idle_pct     = 0;
        hold_done    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                idle_left = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end else begin
                stretch_left--;
            end
            if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready   <= 1'b1;
                idle_left = pick_gap(idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random requests, drain, verdict.
    // ------------------------------------------------------------------------
    initial begin
        spq_pkg::in_word_t w;
        int                i;
        int                k;
        int                mode;
        int                pick;
        int                idle_pct;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        long_hold_req  = 1'b0;

        // Directed table. Empty-queue serves, dismiss and every add have a
        // status that is known without any prediction.
        add_row(spq_pkg::REQ_SERVE_ONE, spq_pkg::CLASS_NONE, 16'h0000, 1'b1,
                spq_pkg::STATUS_EMPTY);
        add_row(spq_pkg::REQ_SERVE_ALL, spq_pkg::CLASS_NONE, 16'h0000, 1'b1,
                spq_pkg::STATUS_EMPTY);
        add_row(spq_pkg::REQ_DISMISS, spq_pkg::CLASS_NONE, 16'hFFFF, 1'b1,
                spq_pkg::STATUS_OK);
        // Class zero clamps to VVIP and the top class value clamps to guest.
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_NONE, 16'h0000, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, 3'd7, 16'hFFFF, 1'b1, spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_GUEST, 16'h1234, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_MEMBER, 16'h5A5A, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_VIP, 16'h00FF, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_VVIP, 16'hAAAA, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_SERVE_ONE, spq_pkg::CLASS_GUEST, 16'h0F0F, 1'b0,
                spq_pkg::STATUS_OK);
        // Fill the line to capacity; the classes run through the clamped range.
        for (k = 0; k < 11; k++) begin
            add_row(spq_pkg::REQ_ADD, 3'(k % 7 + 1), 16'(k * 16'h1111 + 16'h0101),
                    1'b1, spq_pkg::STATUS_OK);
        end
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_VIP, 16'hBEEF, 1'b1,
                spq_pkg::STATUS_FULL);
        add_row(spq_pkg::REQ_SERVE_ALL, spq_pkg::CLASS_MEMBER, 16'h7777, 1'b0,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_ADD, spq_pkg::CLASS_MEMBER, 16'h0001, 1'b1,
                spq_pkg::STATUS_OK);
        add_row(spq_pkg::REQ_DISMISS, spq_pkg::CLASS_VVIP, 16'h8000, 1'b1,
                spq_pkg::STATUS_OK);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_rows[r]) begin
            offer_word(stim_rows[r].word, pick_gap(30), stim_rows[r].has_want,
                       stim_rows[r].want_status);
        end

        // Random requests in stretches of sixteen. Add-heavy stretches push
        // the line into the full case, serve-heavy ones drain it, and the
        // quiet mode offers words back to back.
        mode     = 0;
        idle_pct = 30;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 16 == 0) begin
                mode     = $urandom_range(0, 3);
                idle_pct = (mode == 3) ? 0 : 30;
            end
            if (i == HOLD_AT_ITEM) begin
                long_hold_req = 1'b1;
            end
            if (i == PAUSE_AT_ITEM) begin
                wait_for_drain();
            end
            pick = $urandom_range(0, 99);
            case (mode)
                0: begin
                    w.req_type = (pick < 80) ? spq_pkg::REQ_ADD :
                                 (pick < 92) ? spq_pkg::REQ_SERVE_ONE :
                                 (pick < 97) ? spq_pkg::REQ_SERVE_ALL :
                                               spq_pkg::REQ_DISMISS;
                end
                2: begin
                    w.req_type = (pick < 30) ? spq_pkg::REQ_ADD :
                                 (pick < 80) ? spq_pkg::REQ_SERVE_ONE :
                                 (pick < 95) ? spq_pkg::REQ_SERVE_ALL :
                                               spq_pkg::REQ_DISMISS;
                end
                default: begin
                    w.req_type = (pick < 55) ? spq_pkg::REQ_ADD :
                                 (pick < 85) ? spq_pkg::REQ_SERVE_ONE :
                                 (pick < 95) ? spq_pkg::REQ_SERVE_ALL :
                                               spq_pkg::REQ_DISMISS;
                end
            endcase
            // Mostly legal classes, with the out-of-range codes mixed in.
            if ($urandom_range(0, 99) < 85) begin
                w.priority_class = 3'($urandom_range(1, 4));
            end else begin
                w.priority_class = 3'($urandom_range(0, 7));
            end
            w.guest_tag = 16'($urandom);
            offer_word(w, pick_gap(idle_pct), 1'b0, spq_pkg::STATUS_OK);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
tb/stable_priority_queue_top_tb.sv
